FILE: hw/rtl/fwhb_pkg.sv
// ----------------------------------------------------------------------------
// fwhb_pkg
// Shared types and constants for the fixed bin width histogram.
// ----------------------------------------------------------------------------
package fwhb_pkg;

  localparam int NUM_BINS = 1024;
  localparam int IDX_W    = $clog2(NUM_BINS);
  localparam int COUNT_W  = 32;
  localparam int SAMPLE_W = 32;
  localparam int WIDTH_W  = 31;
  localparam int NBINS_W  = 11;
  localparam int EDGE_W   = 43;
  localparam int PROD_W   = IDX_W + WIDTH_W;
  localparam int SWEEP_W  = IDX_W + 1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CFG_BOTTOM = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_NBINS  = 2'd2,
    CFG_SPARE  = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] bottom_edge;
    logic [WIDTH_W-1:0]         bin_width;
    logic [NBINS_W-1:0]         num_bins;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    opcode_t          op;
    logic [IDX_W-1:0] idx;
    logic             oor;
  } entry_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  function automatic logic [NBINS_W-1:0] bins_in_use(input logic [NBINS_W-1:0] n);
    bins_in_use = (n > NBINS_W'(NUM_BINS)) ? NBINS_W'(NUM_BINS) : n;
  endfunction

  function automatic logic [EDGE_W-1:0] edge_of(input logic signed [SAMPLE_W-1:0] b,
                                                input logic [PROD_W-1:0] prod);
    edge_of = {{(EDGE_W-SAMPLE_W){b[SAMPLE_W-1]}}, b}
            + {{(EDGE_W-PROD_W){1'b0}}, prod};
  endfunction

endpackage

FILE: hw/rtl/fixed_width_histogram_binner.sv
// ----------------------------------------------------------------------------
// fixed_width_histogram_binner
// Fixed bin width histogram: add sample, read bin, clear, running max.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// in       | in_valid / in_stall  | opcode, sample, bin_index
// out      | out_valid / out_stall| bin_count, bin_low_edge, out_of_range,
//          |                      | max_count, max_bin_index, max_bin_edge
// cfg      | cfg_we               | cfg_index, cfg_data
//
// An add runs the 32-step bit-serial divider in the front unless its sample
// lies below the bottom edge or the width is zero. A clear sweeps the
// 1024-entry count RAM, one entry a cycle. After reset the same sweep runs
// with in_stall high. A two-entry queue parts front and back, and the result
// register holds under out_stall while the front takes items until it is full.
// ----------------------------------------------------------------------------
module fixed_width_histogram_binner import fwhb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [SAMPLE_W-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [IDX_W-1:0]    bin_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  bin_count,
  output logic [EDGE_W-1:0]   bin_low_edge,
  output logic                out_of_range,
  output logic [COUNT_W-1:0]  max_count,
  output logic [IDX_W-1:0]    max_bin_index,
  output logic [EDGE_W-1:0]   max_bin_edge
);

  cfg_t         cfg;
  back_status_t bstat;
  logic         q_push, q_pop, q_full, q_empty;
  entry_t       q_din, q_dout;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bottom_edge <= '0;
      cfg.bin_width   <= WIDTH_W'(65536);
      cfg.num_bins    <= NBINS_W'(NUM_BINS);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_BOTTOM: cfg.bottom_edge <= cfg_data;
        CFG_WIDTH:  cfg.bin_width   <= cfg_data[WIDTH_W-1:0];
        CFG_NBINS:  cfg.num_bins    <= cfg_data[NBINS_W-1:0];
        CFG_SPARE:  ;
      endcase
    end
  end

  fwhb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .bstat     (bstat),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .sample    (sample),
    .bin_index (bin_index),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_din     (q_din)
  );

  fwhb_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  fwhb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .bstat         (bstat),
    .q_empty       (q_empty),
    .q_dout        (q_dout),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .bin_count     (bin_count),
    .bin_low_edge  (bin_low_edge),
    .out_of_range  (out_of_range),
    .max_count     (max_count),
    .max_bin_index (max_bin_index),
    .max_bin_edge  (max_bin_edge)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(q_push && q_full && !q_pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(q_pop && q_empty))
    else $error("queue pop while empty");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_of_range |-> bin_count == '0 && bin_low_edge == '0)
    else $error("out of range result carries a count");

  a_max_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count <= max_count)
    else $error("bin count above running max");

endmodule

FILE: hw/rtl/fwhb_ram.sv
// ----------------------------------------------------------------------------
// fwhb_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module fwhb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/fwhb_front.sv
// ----------------------------------------------------------------------------
// fwhb_front
// Accepts items, bins samples with a bit-serial divider, queues the result.
// ----------------------------------------------------------------------------
module fwhb_front import fwhb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  back_status_t        bstat,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [IDX_W-1:0]    bin_index,
  input  logic                q_full,
  output logic                q_push,
  output entry_t              q_din
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_DIV  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t state, state_next;

  logic [SAMPLE_W-1:0] dvd, rem, quo;
  logic [4:0]          step;
  entry_t              ent;

  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   rem_sh;
  logic                take;
  logic [NBINS_W-1:0]  inuse;
  logic                accept;
  opcode_t             op_in;

  assign op_in  = opcode_t'(opcode);
  assign inuse  = bins_in_use(cfg.num_bins);
  assign diff   = {sample[SAMPLE_W-1], sample}
                - {cfg.bottom_edge[SAMPLE_W-1], cfg.bottom_edge};
  assign rem_sh = {rem, dvd[SAMPLE_W-1]};
  assign take   = rem_sh >= {2'b00, cfg.bin_width};

  assign in_stall = (state != F_IDLE) || bstat.init_busy;
  assign accept   = in_valid && !in_stall;
  assign q_push   = (state == F_PUSH) && !q_full;
  assign q_din    = ent;

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (op_in == OP_ADD && !diff[SAMPLE_W] && cfg.bin_width != '0) begin
            state_next = F_DIV;
          end else begin
            state_next = F_PUSH;
          end
        end
      end
      F_DIV:  if (step == '0) state_next = F_PUSH;
      F_PUSH: if (!q_full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          ent.op <= op_in;
          dvd    <= diff[SAMPLE_W-1:0];
          rem    <= '0;
          quo    <= '0;
          step   <= 5'd31;
          unique case (op_in)
            OP_ADD: begin
              ent.idx <= '0;
              ent.oor <= 1'b1;  // cleared below if the divide lands in range
            end
            OP_READ: begin
              ent.idx <= bin_index;
              ent.oor <= {1'b0, bin_index} >= inuse;
            end
            OP_CLEAR: begin
              ent.idx <= '0;
              ent.oor <= 1'b0;
            end
            OP_NONE: begin
              ent.idx <= '0;
              ent.oor <= 1'b1;
            end
          endcase
        end
      end
      F_DIV: begin
        rem  <= take ? SAMPLE_W'(rem_sh - {2'b00, cfg.bin_width}) : rem_sh[SAMPLE_W-1:0];
        dvd  <= {dvd[SAMPLE_W-2:0], 1'b0};
        quo  <= {quo[SAMPLE_W-2:0], take};
        step <= step - 5'd1;
        if (step == '0) begin
          ent.idx <= {quo[IDX_W-2:0], take};
          ent.oor <= {quo[SAMPLE_W-2:0], take} >= {{(SAMPLE_W-NBINS_W){1'b0}}, inuse};
        end
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/fwhb_queue.sv
// ----------------------------------------------------------------------------
// fwhb_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module fwhb_queue import fwhb_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t din,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t dout
);

  entry_t     slot [2];
  logic       wptr, rptr;
  logic [1:0] fill;

  assign full  = fill == 2'd2;
  assign empty = fill == 2'd0;
  assign dout  = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: hw/rtl/fwhb_back.sv
// ----------------------------------------------------------------------------
// fwhb_back
// Carries out queued items on the count RAM and drives the result register.
// ----------------------------------------------------------------------------
module fwhb_back import fwhb_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  output back_status_t        bstat,
  input  logic                q_empty,
  input  entry_t              q_dout,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [COUNT_W-1:0]  bin_count,
  output logic [EDGE_W-1:0]   bin_low_edge,
  output logic                out_of_range,
  output logic [COUNT_W-1:0]  max_count,
  output logic [IDX_W-1:0]    max_bin_index,
  output logic [EDGE_W-1:0]   max_bin_edge
);

  typedef enum logic [5:0] {
    B_INIT = 6'b000001,
    B_IDLE = 6'b000010,
    B_CLR  = 6'b000100,
    B_RD   = 6'b001000,
    B_EDGE = 6'b010000,
    B_OUT  = 6'b100000
  } bstate_t;

  bstate_t state, state_next;

  entry_t              e;
  logic [SWEEP_W-1:0]  sweep;
  logic [COUNT_W-1:0]  run_max, cnt;
  logic [IDX_W-1:0]    run_idx;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [COUNT_W-1:0]  ram_wdata, ram_rdata, c_inc;
  logic [PROD_W-1:0]   prod_e, prod_m;
  logic                sweep_done;

  fwhb_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_BINS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign bstat.init_busy = state == B_INIT;
  assign sweep_done      = sweep == SWEEP_W'(NUM_BINS - 1);
  assign q_pop           = (state == B_IDLE) && !q_empty;
  assign ram_raddr       = q_dout.idx;
  assign c_inc           = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign prod_e          = PROD_W'(e.idx) * PROD_W'(cfg.bin_width);
  assign prod_m          = PROD_W'(run_idx) * PROD_W'(cfg.bin_width);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = e.idx;
    ram_wdata = c_inc;
    if (state == B_INIT || state == B_CLR) begin
      ram_we    = 1'b1;
      ram_waddr = sweep[IDX_W-1:0];
      ram_wdata = '0;
    end else if (state == B_RD && e.op == OP_ADD) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_INIT: if (sweep_done) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          priority if (q_dout.oor)              state_next = B_EDGE;
          else if (q_dout.op == OP_CLEAR)       state_next = B_CLR;
          else                                  state_next = B_RD;
        end
      end
      B_CLR:  if (sweep_done) state_next = B_EDGE;
      B_RD:   state_next = B_EDGE;
      B_EDGE: state_next = B_OUT;
      B_OUT:  if (!out_stall) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_INIT;
      sweep     <= '0;
      run_max   <= '0;
      run_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_INIT || state == B_CLR) begin
        sweep <= sweep_done ? '0 : sweep + 1'b1;
      end
      if (state == B_CLR) begin
        run_max <= '0;
        run_idx <= '0;
      end
      if (state == B_RD && e.op == OP_ADD &&
          (c_inc > run_max || (c_inc == run_max && e.idx < run_idx))) begin
        run_max <= c_inc;
        run_idx <= e.idx;
      end
      if (state == B_EDGE) out_valid <= 1'b1;
      else if (state == B_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) e <= q_dout;
    if (state == B_RD) cnt <= (e.op == OP_ADD) ? c_inc : ram_rdata;
    if (state == B_EDGE) begin
      // only a read or add that landed in range reports its bin
      if (e.oor || e.op == OP_CLEAR) begin
        bin_count    <= '0;
        bin_low_edge <= '0;
      end else begin
        bin_count    <= cnt;
        bin_low_edge <= edge_of(cfg.bottom_edge, prod_e);
      end
      out_of_range  <= e.oor;
      max_count     <= run_max;
      max_bin_index <= run_idx;
      max_bin_edge  <= edge_of(cfg.bottom_edge, prod_m);
    end
  end

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives add, read, clear and no-op items through the histogram binner under
// random gaps and stalls, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import fwhb_pkg::*;

typedef struct {
  logic [COUNT_W-1:0] bin_count;
  logic [EDGE_W-1:0]  bin_low_edge;
  logic               out_of_range;
  logic [COUNT_W-1:0] max_count;
  logic [IDX_W-1:0]   max_bin_index;
  logic [EDGE_W-1:0]  max_bin_edge;
} hist_result_t;

class hist_scoreboard;
  logic [COUNT_W-1:0] counts [NUM_BINS];
  logic [COUNT_W-1:0] peak;
  logic [IDX_W-1:0]   peak_idx;
  logic signed [SAMPLE_W-1:0] bottom;
  logic [WIDTH_W-1:0] width;
  logic [NBINS_W-1:0] nbins;
  hist_result_t pending [$];
  int errors;
  int n_adds, n_reads, n_clears, n_oor;

  function new();
    foreach (counts[i]) counts[i] = '0;
    peak = '0; peak_idx = '0;
    bottom = '0; width = 31'd65536; nbins = 11'd1024;
    errors = 0; n_adds = 0; n_reads = 0; n_clears = 0; n_oor = 0;
  endfunction

  function void set_reg(cfg_index_t idx, logic [SAMPLE_W-1:0] val);
    case (idx)
      CFG_BOTTOM: bottom = val;
      CFG_WIDTH:  width = val[WIDTH_W-1:0];
      CFG_NBINS:  nbins = val[NBINS_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [EDGE_W-1:0] lower_edge(logic [IDX_W-1:0] idx);
    logic signed [63:0] e;
    e = 64'(bottom) + 64'(idx) * 64'(width);
    return e[EDGE_W-1:0];
  endfunction

  function void note_item(opcode_t op, logic [SAMPLE_W-1:0] smp, logic [IDX_W-1:0] bi);
    hist_result_t r;
    logic signed [63:0] diff;
    logic [63:0] idx;
    int unsigned used;
    used = (nbins > NUM_BINS) ? NUM_BINS : nbins;
    r.bin_count = '0; r.bin_low_edge = '0; r.out_of_range = 1'b1;
    case (op)
      OP_ADD: begin
        n_adds++;
        diff = 64'($signed(smp)) - 64'(bottom);
        if (diff >= 0 && width != 0) begin
          idx = diff / 64'(width);
          if (idx < used) begin
            if (counts[idx] != '1) counts[idx]++;
            if (counts[idx] > peak || (counts[idx] == peak && idx < peak_idx)) begin
              peak = counts[idx];
              peak_idx = idx[IDX_W-1:0];
            end
            r.bin_count = counts[idx];
            r.bin_low_edge = lower_edge(idx[IDX_W-1:0]);
            r.out_of_range = 1'b0;
          end
        end
      end
      OP_READ: begin
        n_reads++;
        if (bi < used) begin
          r.bin_count = counts[bi];
          r.bin_low_edge = lower_edge(bi);
          r.out_of_range = 1'b0;
        end
      end
      OP_CLEAR: begin
        n_clears++;
        foreach (counts[i]) counts[i] = '0;
        peak = '0; peak_idx = '0;
        r.out_of_range = 1'b0;
      end
      default: ;
    endcase
    if (r.out_of_range) n_oor++;
    r.max_count = peak;
    r.max_bin_index = peak_idx;
    r.max_bin_edge = lower_edge(peak_idx);
    pending.push_back(r);
  endfunction

  function void check_result(hist_result_t got);
    hist_result_t want;
    if (pending.size() == 0) begin
      $error("result with no item outstanding");
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got.bin_count !== want.bin_count) begin
      $error("bin_count exp %0h got %0h", want.bin_count, got.bin_count); errors++;
    end
    if (got.bin_low_edge !== want.bin_low_edge) begin
      $error("bin_low_edge exp %0h got %0h", want.bin_low_edge, got.bin_low_edge); errors++;
    end
    if (got.out_of_range !== want.out_of_range) begin
      $error("out_of_range exp %0h got %0h", want.out_of_range, got.out_of_range); errors++;
    end
    if (got.max_count !== want.max_count) begin
      $error("max_count exp %0h got %0h", want.max_count, got.max_count); errors++;
    end
    if (got.max_bin_index !== want.max_bin_index) begin
      $error("max_bin_index exp %0h got %0h", want.max_bin_index, got.max_bin_index);
      errors++;
    end
    if (got.max_bin_edge !== want.max_bin_edge) begin
      $error("max_bin_edge exp %0h got %0h", want.max_bin_edge, got.max_bin_edge); errors++;
    end
  endfunction
endclass

module testbench;
  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [SAMPLE_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] opcode = '0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic [IDX_W-1:0] bin_index = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [COUNT_W-1:0] bin_count;
  logic [EDGE_W-1:0] bin_low_edge;
  logic out_of_range;
  logic [COUNT_W-1:0] max_count;
  logic [IDX_W-1:0] max_bin_index;
  logic [EDGE_W-1:0] max_bin_edge;

  hist_scoreboard sb = new();
  int cycles = 0;
  bit hold_off = 1'b0;
  bit stall_random = 1'b1;
  int results_seen = 0;

  fixed_width_histogram_binner u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    hist_result_t r;
    if (!rst && out_valid && !out_stall) begin
      r.bin_count = bin_count; r.bin_low_edge = bin_low_edge;
      r.out_of_range = out_of_range; r.max_count = max_count;
      r.max_bin_index = max_bin_index; r.max_bin_edge = max_bin_edge;
      sb.check_result(r);
      results_seen++;
    end
  end

  // receiver stall: random per item, or a long hold-off when asked
  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (400) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_random && out_valid) begin
        gap = $urandom_range(0, 5);
        if (gap != 0 && $urandom_range(0, 3) != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(negedge clk);
          out_stall <= 1'b0;
        end else begin
          out_stall <= 1'b0;
        end
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // valid stays high into a back-to-back item; drain() drops it at the end
  task automatic send_item(opcode_t op, logic [SAMPLE_W-1:0] smp,
                           logic [IDX_W-1:0] bi, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    sample <= smp;
    bin_index <= bi;
    do @(posedge clk); while (in_stall);
    sb.note_item(op, smp, bi);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(cfg_index_t idx, logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic config_set(logic [SAMPLE_W-1:0] b, logic [SAMPLE_W-1:0] w,
                            logic [SAMPLE_W-1:0] n);
    drain();
    write_reg(CFG_BOTTOM, b);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_NBINS, n);
  endtask

  // sample drawn mostly inside the configured range
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    logic [63:0] span;
    logic signed [63:0] s;
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 7) begin
      span = 64'(sb.width) * 64'($urandom_range(0, sb.nbins + 1));
      s = 64'(sb.bottom) + span + 64'($urandom_range(0, 3)) - 2;
      if (s > 64'sd2147483647 || s < -64'sd2147483648) return $urandom();
      return s[31:0];
    end
    return $urandom();
  endfunction

  function automatic opcode_t pick_op();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 70) return OP_ADD;
    if (k < 96) return OP_READ;
    if (k < 98) return OP_NONE;
    return OP_CLEAR;
  endfunction

  task automatic random_phase(int n, bit gaps);
    opcode_t op;
    int gap;
    for (int i = 0; i < n; i++) begin
      op = pick_op();
      gap = (gaps && $urandom_range(0, 1)) ? $urandom_range(0, 5) : 0;
      send_item(op, pick_sample(), IDX_W'($urandom_range(0, NUM_BINS - 1)), gap);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset config, extremes and every opcode
    send_item(OP_ADD, 32'h0000_0000, '0, 0);
    send_item(OP_ADD, 32'h0000_ffff, '0, 0);
    send_item(OP_ADD, 32'h03ff_ffff, '0, 0);
    send_item(OP_ADD, 32'h0400_0000, '0, 0);
    send_item(OP_ADD, 32'h8000_0000, '0, 0);
    send_item(OP_ADD, 32'h7fff_ffff, '0, 0);
    send_item(OP_ADD, 32'hffff_ffff, '0, 0);
    send_item(OP_ADD, 32'h0001_0000, '0, 0);
    send_item(OP_ADD, 32'h0001_0000, '0, 0);
    send_item(OP_READ, '0, 10'd1, 0);
    send_item(OP_READ, '0, 10'd1023, 0);
    send_item(OP_NONE, 32'hffff_ffff, 10'h3ff, 0);
    send_item(OP_CLEAR, '0, '0, 0);
    send_item(OP_READ, '0, 10'd1, 0);

    // extreme registers: most negative bottom, widest width, zero bins
    config_set(32'h8000_0000, 32'h7fff_ffff, 32'd2);
    send_item(OP_ADD, 32'h8000_0000, '0, 0);
    send_item(OP_ADD, 32'h7fff_ffff, '0, 0);
    send_item(OP_ADD, 32'hffff_fffe, '0, 0);
    send_item(OP_READ, '0, 10'd1, 0);
    send_item(OP_READ, '0, 10'd2, 0);
    config_set(32'h7fff_ffff, 32'd1, 32'd0);
    send_item(OP_ADD, 32'h7fff_ffff, '0, 0);
    send_item(OP_READ, '0, '0, 0);
    config_set(32'hfff0_0000, 32'd1, 32'h7ff);
    send_item(OP_ADD, 32'hfff0_03ff, '0, 0);
    send_item(OP_ADD, 32'hfff0_0400, '0, 0);
    send_item(OP_READ, '0, 10'd1023, 0);

    // random phases over several settings
    config_set(32'hfffe_0000, 32'h0000_4000, 32'd16);
    random_phase(150, 1'b1);
    config_set($urandom(), $urandom_range(1, 32'h7fff_ffff), $urandom_range(1, 1024));
    random_phase(100, 1'b1);
    // shrink then regrow: kept counts come back
    config_set(32'd0, 32'd3, 32'd4);
    random_phase(80, 1'b1);
    drain();
    write_reg(CFG_NBINS, 32'd1024);
    random_phase(80, 1'b0);

    // long receiver hold-off while the sender keeps pushing
    drain();
    hold_off = 1'b1;
    random_phase(40, 1'b0);
    // sender pause until everything is back
    drain();
    config_set(32'h0010_0000, 32'h0000_0100, 32'd64);
    stall_random = 1'b0;
    random_phase(150, 1'b0);
    stall_random = 1'b1;
    config_set(32'hffff_0000, 32'd7, 32'd1000);
    random_phase(250, 1'b1);
    drain();
    repeat (100) @(negedge clk);

    $display("covered %0d adds, %0d reads, %0d clears; %0d out-of-range items",
             sb.n_adds, sb.n_reads, sb.n_clears, sb.n_oor);
    $display("%0d results checked, %0d mismatches", results_seen, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

FILE: sim.f
hw/rtl/fwhb_pkg.sv
hw/rtl/fwhb_ram.sv
hw/rtl/fwhb_front.sv
hw/rtl/fwhb_queue.sv
hw/rtl/fwhb_back.sv
hw/rtl/fixed_width_histogram_binner.sv
tb/testbench.sv
